@@ design/asn1_length_decoder_macros.svh @@
// Assertion macros for the ASN.1 length decoder.
`ifndef ASN1_LENGTH_DECODER_MACROS_SVH
`define ASN1_LENGTH_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define ALD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ALD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ALD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/ald_pkg.sv @@
// Types and constants shared by the ASN.1 length decoder.
package ald_pkg;

    localparam int INDEX_BITS     = 32;
    localparam int LEN_BITS       = 64;
    localparam int CNT_BITS       = 4;

    localparam logic [7:0] SHORT_LIMIT    = 8'h80;
    localparam logic [7:0] MAX_LONG_CODE  = 8'h88;
    localparam logic [CNT_BITS-1:0] MAX_LONG_BYTES = 4'd8;
    localparam logic [LEN_BITS-1:0] ALL_ONES = '1;

    localparam logic [1:0] ST_DEFINITE   = 2'd0;
    localparam logic [1:0] ST_INDEFINITE = 2'd1;
    localparam logic [1:0] ST_SHORT_DATA = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd3;

    typedef struct packed {
        logic [7:0]            length_byte;
        logic                  first;
        logic [INDEX_BITS-1:0] byte_index;
        logic [INDEX_BITS-1:0] buffer_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [LEN_BITS-1:0]   content_length;
        logic [INDEX_BITS-1:0] next_index;
    } t_out_item;

endpackage

@@ design/asn1_length_decoder.sv @@
// ASN.1 BER/DER length decoder: top level, one byte per item.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one byte of a
// length field per item; the first byte of a field has first set and brings
// its buffer position and the buffer length. Output channel (o_out_valid /
// i_out_stall / o_out_item) carries one result per finished decode: short
// form and indefinite form finish on their first byte, long form on its last
// length byte; errors finish the decode at once. Bytes without first and no
// decode pending give no result.
// An item is registered on accept and decoded into the result register once
// the output side can advance, so a decode can wait behind a stalled result.
// One item per cycle is accepted while o_in_stall is low; the decode state
// sits in flip-flops and is updated for each item that is processed.
// While a result waits under stall the input register still fills once,
// after which o_in_stall follows i_out_stall.
// Reset (synchronous, active low) empties both registers and drops any
// pending decode.
module asn1_length_decoder
    import ald_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

`include "asn1_length_decoder_macros.svh"

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  r_pending;
    logic [CNT_BITS-1:0]   r_bytes_left;
    logic [CNT_BITS-1:0]   r_long_count;
    logic [LEN_BITS-1:0]   r_acc;
    logic [INDEX_BITS:0]   r_cur_index;
    logic [INDEX_BITS-1:0] r_limit;

    logic                  n_pending;
    logic [CNT_BITS-1:0]   n_bytes_left;
    logic [CNT_BITS-1:0]   n_long_count;
    logic [LEN_BITS-1:0]   n_acc;
    logic [INDEX_BITS:0]   n_cur_index;
    logic [INDEX_BITS-1:0] n_limit;

    logic                  advance;
    logic                  process;
    logic                  in_accept;
    logic                  emit;
    t_out_item             result;

    logic [INDEX_BITS-1:0] pos1;
    logic [INDEX_BITS-1:0] room_first;
    logic [INDEX_BITS:0]   cur_inc;
    logic [INDEX_BITS:0]   room_long;

    assign advance    = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // pos1 cannot wrap: it is only used once byte_index < buffer_length
    assign pos1       = r_in.byte_index + INDEX_BITS'(1);
    assign room_first = r_in.buffer_length - pos1;
    assign cur_inc    = r_cur_index + (INDEX_BITS+1)'(1);
    assign room_long  = {1'b0, r_limit} - cur_inc;

    always_comb begin
        n_pending    = r_pending;
        n_bytes_left = r_bytes_left;
        n_long_count = r_long_count;
        n_acc        = r_acc;
        n_cur_index  = r_cur_index;
        n_limit      = r_limit;
        emit         = 1'b0;
        result       = '0;
        if (r_in.first) begin
            n_limit   = r_in.buffer_length;
            n_pending = 1'b0;
            emit      = 1'b1;
            if (r_in.byte_index >= r_in.buffer_length) begin
                result.status = ST_SHORT_DATA;
            end else if (r_in.length_byte < SHORT_LIMIT) begin
                if ({{(INDEX_BITS-8){1'b0}}, r_in.length_byte} > room_first) begin
                    result.status = ST_SHORT_DATA;
                end else begin
                    result.status         = ST_DEFINITE;
                    result.content_length = {{(LEN_BITS-8){1'b0}}, r_in.length_byte};
                    result.next_index     = pos1;
                end
            end else if (r_in.length_byte == SHORT_LIMIT) begin
                result.status         = ST_INDEFINITE;
                result.content_length = ALL_ONES;
                result.next_index     = pos1;
            end else if (r_in.length_byte > MAX_LONG_CODE) begin
                result.status = ST_TOO_LARGE;
            end else if ({{(INDEX_BITS-CNT_BITS){1'b0}}, r_in.length_byte[CNT_BITS-1:0]}
                         > room_first) begin
                result.status = ST_SHORT_DATA;
            end else begin
                // long form: wait for the announced length bytes
                emit         = 1'b0;
                n_pending    = 1'b1;
                n_bytes_left = r_in.length_byte[CNT_BITS-1:0];
                n_long_count = r_in.length_byte[CNT_BITS-1:0];
                n_acc        = '0;
                n_cur_index  = {1'b0, pos1};
            end
        end else if (r_pending) begin
            n_acc        = {r_acc[LEN_BITS-9:0], r_in.length_byte};
            n_cur_index  = cur_inc;
            n_bytes_left = r_bytes_left - CNT_BITS'(1);
            if (n_bytes_left == '0) begin
                n_pending = 1'b0;
                emit      = 1'b1;
                if (r_long_count == MAX_LONG_BYTES && n_acc == ALL_ONES) begin
                    result.status = ST_TOO_LARGE;
                end else if (n_acc > {{(LEN_BITS-INDEX_BITS-1){1'b0}}, room_long}) begin
                    result.status = ST_SHORT_DATA;
                end else begin
                    result.status         = ST_DEFINITE;
                    result.content_length = n_acc;
                    result.next_index     = n_cur_index[INDEX_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pending    <= 1'b0;
            r_bytes_left <= '0;
            r_long_count <= '0;
            r_acc        <= '0;
            r_cur_index  <= '0;
            r_limit      <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_pending    <= n_pending;
                r_bytes_left <= n_bytes_left;
                r_long_count <= n_long_count;
                r_acc        <= n_acc;
                r_cur_index  <= n_cur_index;
                r_limit      <= n_limit;
            end
            if (process && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: input loads on accept, result loads on emit; both hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
        if (process && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ALD_ASSERT_IMP(a_pending_count, i_clk, i_rst_n, r_pending,
        r_bytes_left != '0 && r_bytes_left <= r_long_count && r_long_count <= MAX_LONG_BYTES)
    `ALD_ASSERT_IMP(a_pending_in_buffer, i_clk, i_rst_n, r_pending,
        r_cur_index <= {1'b0, r_limit})
    `ALD_ASSERT_IMP(a_error_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.status == ST_SHORT_DATA || r_out.status == ST_TOO_LARGE),
        r_out.content_length == '0 && r_out.next_index == '0)
    `ALD_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall,
        r_in_valid && r_out_valid)
    `ALD_ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, process && emit, r_out_valid)

endmodule
